// ----- src/drt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package drt_pkg;

  localparam int SLOTS      = 8;
  localparam int COORD_BITS = 12;
  localparam int SLOT_W     = $clog2(SLOTS);

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

  localparam logic [1:0] KIND_MARK  = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] w;
    logic [COORD_BITS-1:0] h;
  } rect_t;

  // Strict overlap on both axes, edges computed one bit wider
  function automatic logic overlap(rect_t a, rect_t b);
    logic [COORD_BITS:0] ae;
    logic [COORD_BITS:0] be;
    logic [COORD_BITS:0] af;
    logic [COORD_BITS:0] bf;
    ae = {1'b0, a.x} + {1'b0, a.w};
    be = {1'b0, b.x} + {1'b0, b.w};
    af = {1'b0, a.y} + {1'b0, a.h};
    bf = {1'b0, b.y} + {1'b0, b.h};
    overlap = ({1'b0, a.x} < be) && ({1'b0, b.x} < ae) &&
              ({1'b0, a.y} < bf) && ({1'b0, b.y} < af);
  endfunction

  // Smallest rectangle that covers both
  function automatic rect_t grow(rect_t a, rect_t b);
    logic [COORD_BITS-1:0] x1;
    logic [COORD_BITS-1:0] y1;
    logic [COORD_BITS:0]   ae;
    logic [COORD_BITS:0]   be;
    logic [COORD_BITS:0]   af;
    logic [COORD_BITS:0]   bf;
    logic [COORD_BITS:0]   x2;
    logic [COORD_BITS:0]   y2;
    logic [COORD_BITS:0]   dw;
    logic [COORD_BITS:0]   dh;
    x1 = (a.x < b.x) ? a.x : b.x;
    y1 = (a.y < b.y) ? a.y : b.y;
    ae = {1'b0, a.x} + {1'b0, a.w};
    be = {1'b0, b.x} + {1'b0, b.w};
    af = {1'b0, a.y} + {1'b0, a.h};
    bf = {1'b0, b.y} + {1'b0, b.h};
    x2 = (ae > be) ? ae : be;
    y2 = (af > bf) ? af : bf;
    dw = x2 - {1'b0, x1};
    dh = y2 - {1'b0, y1};
    grow.x = x1;
    grow.y = y1;
    grow.w = dw[COORD_BITS-1:0];
    grow.h = dh[COORD_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- src/dirty_rectangle_tracker_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// A kept mark scans the table once to merge (a read state and an evaluate state per slot, plus
// a write-back state when the first hit is not the last slot) and once for the status; clear,
// read, unknown and dropped items make only the status scan. The next start is taken at the
// edge that ends the result beat: one item at a time, paced by the slot memory's single read
// port. done cannot be stalled.
// Synchronous reset empties the table and loads 128 x 160.
module dirty_rectangle_tracker_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  output logic             done,
  input  wire logic [1:0]  kind,
  input  wire logic [11:0] region_x,
  input  wire logic [11:0] region_y,
  input  wire logic [11:0] region_w,
  input  wire logic [11:0] region_h,
  input  wire logic [2:0]  slot_index,
  output logic [3:0]       valid_count,
  output logic             bound_valid,
  output logic [11:0]      bound_x,
  output logic [11:0]      bound_y,
  output logic [11:0]      bound_w,
  output logic [11:0]      bound_h,
  output logic             entry_valid,
  output logic [11:0]      entry_x,
  output logic [11:0]      entry_y,
  output logic [11:0]      entry_w,
  output logic [11:0]      entry_h,
  output logic             collapsed,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_FIND_R = 8'b0000_0010,
    ST_FIND_E = 8'b0000_0100,
    ST_ABS_R  = 8'b0000_1000,
    ST_ABS_E  = 8'b0001_0000,
    ST_WB     = 8'b0010_0000,
    ST_STAT_R = 8'b0100_0000,
    ST_STAT_E = 8'b1000_0000
  } state_t;

  state_t state;
  logic   fin;

  logic [11:0] screen_width;
  logic [11:0] screen_height;

  logic [drt_pkg::SLOTS-1:0]  used;
  logic [drt_pkg::SLOT_W-1:0] ptr;
  logic [drt_pkg::SLOT_W-1:0] base;
  drt_pkg::rect_t             mem [drt_pkg::SLOTS];
  drt_pkg::rect_t             rdata;
  drt_pkg::rect_t             cur;
  drt_pkg::rect_t             acc;
  drt_pkg::rect_t             ent;
  logic [1:0]                 cur_kind;
  logic [2:0]                 cur_idx;
  logic                       coll;
  logic                       ent_v;
  logic [3:0]                 cnt;
  logic [11:0]                bx1;
  logic [11:0]                by1;
  logic [12:0]                bx2;
  logic [12:0]                by2;

  // APB register port
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == drt_pkg::REG_HEIGHT) ? {20'd0, screen_height}
                                                    : {20'd0, screen_width};

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= 12'd128;
      screen_height <= 12'd160;
    end else if (cfg_wr) begin
      if (paddr[2] == drt_pkg::REG_WIDTH) screen_width <= pwdata[11:0];
      else screen_height <= pwdata[11:0];
    end
  end

  // Clip the incoming mark
  logic [12:0] x_end;
  logic [12:0] y_end;
  logic [11:0] w_clip;
  logic [11:0] h_clip;
  logic        drop;
  logic        accept;
  assign accept = start && !busy;
  assign x_end  = {1'b0, region_x} + {1'b0, region_w};
  assign y_end  = {1'b0, region_y} + {1'b0, region_h};
  assign w_clip = (x_end > {1'b0, screen_width}) ? (screen_width - region_x) : region_w;
  assign h_clip = (y_end > {1'b0, screen_height}) ? (screen_height - region_y) : region_h;
  assign drop   = (region_x >= screen_width) || (region_y >= screen_height) ||
                  (region_w == 12'd0) || (region_h == 12'd0);

  // First free slot
  logic                       any_free;
  logic [drt_pkg::SLOT_W-1:0] free_slot;
  always_comb begin
    any_free  = 1'b0;
    free_slot = '0;
    for (int i = drt_pkg::SLOTS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        any_free  = 1'b1;
        free_slot = drt_pkg::SLOT_W'(i);
      end
    end
  end

  logic hit_find;
  logic hit_abs;
  assign hit_find = used[ptr] && drt_pkg::overlap(cur, rdata);
  assign hit_abs  = used[ptr] && drt_pkg::overlap(acc, rdata);

  // Memory write port
  logic                       we;
  logic [drt_pkg::SLOT_W-1:0] waddr;
  drt_pkg::rect_t             wdata;
  always_comb begin
    we    = 1'b0;
    waddr = ptr;
    wdata = cur;
    case (state)
      ST_FIND_E: begin
        if (!hit_find && ptr == drt_pkg::LAST_SLOT) begin
          we = 1'b1;
          if (any_free) begin
            waddr = free_slot;
          end else begin
            waddr = '0;
            wdata = '{x: 12'd0, y: 12'd0, w: screen_width, h: screen_height};
          end
        end else if (hit_find && ptr == drt_pkg::LAST_SLOT) begin
          we    = 1'b1;
          wdata = drt_pkg::grow(rdata, cur);
        end
      end
      ST_WB: begin
        we    = 1'b1;
        waddr = base;
        wdata = acc;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[ptr];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      used  <= '0;
      ptr   <= '0;
      fin   <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= fin;
      fin  <= (state == ST_STAT_E) && (ptr == drt_pkg::LAST_SLOT);
      case (state)
        ST_IDLE: begin
          if (accept) begin
            ptr <= '0;
            if (kind == drt_pkg::KIND_MARK && !drop) state <= ST_FIND_R;
            else state <= ST_STAT_R;
            if (kind == drt_pkg::KIND_CLEAR) used <= '0;
          end
        end
        ST_FIND_R: state <= ST_FIND_E;
        ST_FIND_E: begin
          if (hit_find) begin
            base <= ptr;
            if (ptr == drt_pkg::LAST_SLOT) begin
              ptr   <= '0;
              state <= ST_STAT_R;
            end else begin
              ptr   <= ptr + 1'b1;
              state <= ST_ABS_R;
            end
          end else if (ptr == drt_pkg::LAST_SLOT) begin
            if (any_free) begin
              used[free_slot] <= 1'b1;
            end else begin
              used <= drt_pkg::SLOTS'(1);
            end
            ptr   <= '0;
            state <= ST_STAT_R;
          end else begin
            ptr   <= ptr + 1'b1;
            state <= ST_FIND_R;
          end
        end
        ST_ABS_R: state <= ST_ABS_E;
        ST_ABS_E: begin
          if (hit_abs) used[ptr] <= 1'b0;
          if (ptr == drt_pkg::LAST_SLOT) begin
            state <= ST_WB;
          end else begin
            ptr   <= ptr + 1'b1;
            state <= ST_ABS_R;
          end
        end
        ST_WB: begin
          ptr   <= '0;
          state <= ST_STAT_R;
        end
        ST_STAT_R: state <= ST_STAT_E;
        ST_STAT_E: begin
          if (ptr == drt_pkg::LAST_SLOT) begin
            state <= ST_IDLE;
          end else begin
            ptr   <= ptr + 1'b1;
            state <= ST_STAT_R;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign busy = (state != ST_IDLE) || fin;

  // Datapath: latch item, merge accumulator, status scan
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_kind <= kind;
      cur_idx  <= slot_index;
      cur      <= '{x: region_x, y: region_y, w: w_clip, h: h_clip};
      coll     <= 1'b0;
      cnt      <= '0;
      ent_v    <= 1'b0;
    end
    if (state == ST_FIND_E) begin
      if (hit_find) acc <= drt_pkg::grow(rdata, cur);
      else if (ptr == drt_pkg::LAST_SLOT && !any_free) coll <= 1'b1;
    end
    if (state == ST_ABS_E && hit_abs) acc <= drt_pkg::grow(acc, rdata);
    if (state == ST_STAT_E && used[ptr]) begin
      if (cnt == 4'd0) begin
        bx1 <= rdata.x;
        by1 <= rdata.y;
        bx2 <= {1'b0, rdata.x} + {1'b0, rdata.w};
        by2 <= {1'b0, rdata.y} + {1'b0, rdata.h};
      end else begin
        if (rdata.x < bx1) bx1 <= rdata.x;
        if (rdata.y < by1) by1 <= rdata.y;
        if (({1'b0, rdata.x} + {1'b0, rdata.w}) > bx2) bx2 <= {1'b0, rdata.x} + {1'b0, rdata.w};
        if (({1'b0, rdata.y} + {1'b0, rdata.h}) > by2) by2 <= {1'b0, rdata.y} + {1'b0, rdata.h};
      end
      cnt <= cnt + 4'd1;
      if (cur_kind == drt_pkg::KIND_READ && ptr == cur_idx[drt_pkg::SLOT_W-1:0]) begin
        ent_v <= 1'b1;
        ent   <= rdata;
      end
    end
  end

  // Result beat
  logic [12:0] bw_full;
  logic [12:0] bh_full;
  assign bw_full = bx2 - {1'b0, bx1};
  assign bh_full = by2 - {1'b0, by1};
  always_ff @(posedge clk) begin
    if (fin) begin
      valid_count <= cnt;
      bound_valid <= (cnt != 4'd0);
      bound_x     <= (cnt != 4'd0) ? bx1 : 12'd0;
      bound_y     <= (cnt != 4'd0) ? by1 : 12'd0;
      bound_w     <= (cnt != 4'd0) ? bw_full[11:0] : 12'd0;
      bound_h     <= (cnt != 4'd0) ? bh_full[11:0] : 12'd0;
      entry_valid <= ent_v;
      entry_x     <= ent_v ? ent.x : 12'd0;
      entry_y     <= ent_v ? ent.y : 12'd0;
      entry_w     <= ent_v ? ent.w : 12'd0;
      entry_h     <= ent_v ? ent.h : 12'd0;
      collapsed   <= coll;
    end
  end

  // Checks
  a_done_after_fin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(fin)) else $error("result beat without finished scan");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    done |-> valid_count <= 4'(drt_pkg::SLOTS)) else $error("valid count out of range");
  a_bound_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> bound_valid == (valid_count != 4'd0)) else $error("bound flag mismatch");
  a_collapse_one: assert property (@(posedge clk) disable iff (rst)
    (done && collapsed) |-> valid_count == 4'd1) else $error("collapse left extra slots");

endmodule
`default_nettype wire
